// ===== design/qap_pkg.sv =====
// Package for the quantized average pool unit: sizes, register indexes,
// configuration and internal item types. No dependencies.
`timescale 1ns / 1ps

package qap_pkg;

  localparam int MAX_CHANNELS = 256;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int COUNT_W      = CH_W + 1;
  localparam int ACC_W        = 32;
  localparam int VALUE_W      = 8;
  localparam int PROD_W       = 64;
  localparam int ROUND_W      = 63;
  localparam int SHIFT_W      = 6;
  localparam int ZP_W         = 16;
  localparam int SAT_W        = ZP_W + 2;  // int16 value plus zero point, with sign
  localparam int CFG_DATA_W   = 63;
  localparam int CFG_INDEX_W  = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = QPTR_W + 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS          = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MULTIPLIER    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUNDING      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_AMOUNT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_POINT    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_MIN     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_MAX     = 3'd7;

  typedef struct packed {
    logic [COUNT_W-1:0]        channel_count;
    logic signed [ACC_W-1:0]   bias;
    logic [ACC_W-1:0]          multiplier;
    logic [ROUND_W-1:0]        rounding;
    logic [SHIFT_W-1:0]        shift_amount;
    logic signed [ZP_W-1:0]    zero_point;
    logic [VALUE_W-1:0]        clamp_min;
    logic [VALUE_W-1:0]        clamp_max;
  } cfg_t;

  // Finished window sum handed from the accumulator to the requantizer
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [CH_W-1:0]  channel;
  } sum_item_t;

endpackage

// ===== design/qap_in_if.sv =====
// Input channel of the quantized average pool unit: valid/ready and one byte.
// Depends on qap_pkg.
`timescale 1ns / 1ps

interface qap_in_if;
  logic                        valid;
  logic                        ready;
  logic [qap_pkg::VALUE_W-1:0] value;
  logic                        first_element;
  logic                        last_element;

  modport source (output valid, output value, output first_element,
                  output last_element, input ready);
  modport sink   (input valid, input value, input first_element,
                  input last_element, output ready);
endinterface

// ===== design/qap_out_if.sv =====
// Output channel of the quantized average pool unit: valid/ready, byte, channel.
// Depends on qap_pkg.
`timescale 1ns / 1ps

interface qap_out_if;
  logic                        valid;
  logic                        ready;
  logic [qap_pkg::VALUE_W-1:0] out_value;
  logic [qap_pkg::CH_W-1:0]    out_channel;

  modport source (output valid, output out_value, output out_channel, input ready);
  modport sink   (input valid, input out_value, input out_channel, output ready);
endinterface

// ===== design/qap_front.sv =====
// Front part: channel counter, per-channel accumulator memory and the
// accumulate stage. Pushes finished window sums. Depends on qap_pkg, qap_in_if.
`timescale 1ns / 1ps

module qap_front (
  input  logic                             clk,
  input  logic                             rst,
  qap_in_if.sink                           items,
  input  logic [qap_pkg::COUNT_W-1:0]      channel_count,
  input  logic signed [qap_pkg::ACC_W-1:0] bias,
  output logic                             push_valid,
  output qap_pkg::sum_item_t               push_item,
  input  logic                             push_ready
);

  logic [qap_pkg::ACC_W-1:0] sums [qap_pkg::MAX_CHANNELS];
  logic [qap_pkg::ACC_W-1:0] rd_data;
  logic [qap_pkg::ACC_W-1:0] last_acc;

  logic [qap_pkg::CH_W-1:0]    position;
  logic [qap_pkg::CH_W-1:0]    position_next;
  logic [qap_pkg::COUNT_W-1:0] count_eff;
  logic [qap_pkg::COUNT_W-1:0] pos_plus;

  logic                         s1_valid;
  logic [qap_pkg::VALUE_W-1:0]  s1_value;
  logic                         s1_first;
  logic                         s1_last;
  logic [qap_pkg::CH_W-1:0]     s1_pos;
  logic                         s1_hit;
  logic                         s1_fire;
  logic                         accept;
  logic [qap_pkg::ACC_W-1:0]    base;
  logic [qap_pkg::ACC_W-1:0]    acc;

  // Effective channel count: zero acts as one, large values cap at the maximum
  always_comb begin
    priority if (channel_count == '0) begin
      count_eff = qap_pkg::COUNT_W'(1);
    end else if (channel_count > qap_pkg::COUNT_W'(qap_pkg::MAX_CHANNELS)) begin
      count_eff = qap_pkg::COUNT_W'(qap_pkg::MAX_CHANNELS);
    end else begin
      count_eff = channel_count;
    end
  end

  assign pos_plus      = {1'b0, position} + qap_pkg::COUNT_W'(1);
  assign position_next = (pos_plus >= count_eff) ? '0 : pos_plus[qap_pkg::CH_W-1:0];

  // Accumulate stage handshake
  assign s1_fire     = s1_valid && (!s1_last || push_ready);
  assign items.ready = !s1_valid || s1_fire;
  assign accept      = items.valid && items.ready;

  // Accumulate: a read that raced the previous write to the same channel
  // takes the forwarded sum
  assign base = s1_first ? bias : (s1_hit ? last_acc : rd_data);
  assign acc  = base + qap_pkg::ACC_W'(s1_value);

  assign push_valid        = s1_valid && s1_last;
  assign push_item.acc     = acc;
  assign push_item.channel = s1_pos;

  // Channel counter and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        position <= position_next;
      end
      if (items.ready) begin
        s1_valid <= items.valid;
      end
    end
  end

  // Stage payload and forwarding flag
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value <= items.value;
      s1_first <= items.first_element;
      s1_last  <= items.last_element;
      s1_pos   <= position;
      s1_hit   <= s1_fire && (s1_pos == position);
    end
    if (s1_fire) begin
      last_acc <= acc;
    end
  end

  // Accumulator memory: one registered read, one write
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= sums[position];
    end
    if (s1_fire) begin
      sums[s1_pos] <= acc;
    end
  end

endmodule

// ===== design/qap_queue.sv =====
// Short queue between the accumulator front and the requantizer back.
// Depends on qap_pkg.
`timescale 1ns / 1ps

module qap_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  input  qap_pkg::sum_item_t push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output qap_pkg::sum_item_t pop_item,
  input  logic               pop_ready
);

  qap_pkg::sum_item_t         slots [qap_pkg::QUEUE_DEPTH];
  logic [qap_pkg::QPTR_W-1:0] wr_ptr;
  logic [qap_pkg::QPTR_W-1:0] rd_ptr;
  logic [qap_pkg::QCNT_W-1:0] count;
  logic                       do_push;
  logic                       do_pop;

  assign push_ready = (count != qap_pkg::QCNT_W'(qap_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + qap_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + qap_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + qap_pkg::QCNT_W'(1);
        2'b01:   count <= count - qap_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/qap_back.sv =====
// Back part: five-stage requantizer from window sum to clamped output byte.
// Depends on qap_pkg and qap_out_if.
`timescale 1ns / 1ps

module qap_back (
  input  logic               clk,
  input  logic               rst,
  input  qap_pkg::cfg_t      cfg,
  input  logic               pop_valid,
  input  qap_pkg::sum_item_t pop_item,
  output logic               pop_ready,
  qap_out_if.source          results
);

  logic enable;
  logic v0, v1, v2, v3, v4;

  logic                        neg0, neg1, neg2;
  logic [qap_pkg::CH_W-1:0]    ch0, ch1, ch2, ch3, ch4;
  logic [qap_pkg::ACC_W-1:0]   mag0;
  logic [qap_pkg::PROD_W-1:0]  prod1;
  logic [qap_pkg::PROD_W-1:0]  sum2;
  logic signed [qap_pkg::ACC_W-1:0] sbits3;
  logic [qap_pkg::VALUE_W-1:0] byte4;

  logic [qap_pkg::PROD_W-1:0]  shifted;
  logic [qap_pkg::ACC_W-1:0]   low;
  logic signed [qap_pkg::SAT_W-1:0] s16;
  logic signed [qap_pkg::SAT_W-1:0] with_zp;
  logic [qap_pkg::VALUE_W-1:0] sat_byte;
  logic [qap_pkg::VALUE_W-1:0] upper;
  logic [qap_pkg::VALUE_W-1:0] clamped;

  // Whole pipeline advances unless the output holds an untaken item
  assign enable        = !v4 || results.ready;
  assign pop_ready     = enable;
  assign results.valid = v4;
  assign results.out_value   = byte4;
  assign results.out_channel = ch4;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (enable) begin
      v0 <= pop_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Shift, sign restore
  assign shifted = sum2 >> cfg.shift_amount;
  assign low     = shifted[qap_pkg::ACC_W-1:0];

  // int16 saturation, zero point, byte saturation, clamps
  always_comb begin
    priority if ($signed(sbits3) < -32'sd32768) begin
      s16 = qap_pkg::SAT_W'(-32'sd32768);
    end else if ($signed(sbits3) > 32'sd32767) begin
      s16 = qap_pkg::SAT_W'(32'sd32767);
    end else begin
      s16 = qap_pkg::SAT_W'(sbits3);
    end
    with_zp = s16 + qap_pkg::SAT_W'(cfg.zero_point);
    priority if (with_zp < qap_pkg::SAT_W'(32'sd0)) begin
      sat_byte = '0;
    end else if (with_zp > qap_pkg::SAT_W'(32'sd255)) begin
      sat_byte = 8'hFF;
    end else begin
      sat_byte = with_zp[qap_pkg::VALUE_W-1:0];
    end
    upper   = (sat_byte > cfg.clamp_max) ? cfg.clamp_max : sat_byte;
    clamped = (upper < cfg.clamp_min) ? cfg.clamp_min : upper;
  end

  // Stage payloads: magnitude, product, rounding add, shift, saturate
  always_ff @(posedge clk) begin
    if (enable) begin
      neg0   <= pop_item.acc[qap_pkg::ACC_W-1];
      mag0   <= pop_item.acc[qap_pkg::ACC_W-1] ? (~pop_item.acc + qap_pkg::ACC_W'(1))
                                               : pop_item.acc;
      ch0    <= pop_item.channel;
      neg1   <= neg0;
      prod1  <= qap_pkg::PROD_W'(mag0) * qap_pkg::PROD_W'(cfg.multiplier);
      ch1    <= ch0;
      neg2   <= neg1;
      sum2   <= prod1 + qap_pkg::PROD_W'(cfg.rounding);
      ch2    <= ch1;
      sbits3 <= neg2 ? $signed(~low + qap_pkg::ACC_W'(1)) : $signed(low);
      ch3    <= ch2;
      byte4  <= clamped;
      ch4    <= ch3;
    end
  end

endmodule

// ===== design/quantized_average_pool_unit.sv =====
// Quantized average pool unit: top level with configuration registers.
// Depends on qap_pkg, qap_in_if, qap_out_if, qap_front, qap_queue, qap_back.
//
// Usage: bytes enter on "items" (valid/ready), window-element-major and
// channel-minor; an internal channel counter steps once per accepted item
// and wraps at channel_count. Items flagged last_element yield one result on
// "results" (valid/ready): the requantized, clamped byte and its channel.
// Configuration goes through cfg_we/cfg_index/cfg_data, one register per
// cycle, while the unit is idle.
// Throughput: one item per cycle while results keeps taking its output.
// Path: an accepted item goes from the accumulate stage into the queue,
// then through four requantizer stages and the output register. The
// accumulator memory read and forwarded write let the same channel recur
// on consecutive cycles.
// Reset: channel counter to zero, registers to their reset values, pipeline
// and queue empty; accumulators hold nothing until a first_element item
// loads them.
// Stall: when results stalls, the requantizer holds, the four-entry queue
// fills, and then items.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module quantized_average_pool_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  qap_in_if.sink                               items,
  qap_out_if.source                            results,
  input  logic                                 cfg_we,
  input  logic [qap_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [qap_pkg::CFG_DATA_W-1:0]       cfg_data
);

  qap_pkg::cfg_t      cfg;
  logic               push_valid;
  logic               push_ready;
  qap_pkg::sum_item_t push_item;
  logic               pop_valid;
  logic               pop_ready;
  qap_pkg::sum_item_t pop_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count <= qap_pkg::COUNT_W'(1);
      cfg.bias          <= '0;
      cfg.multiplier    <= '0;
      cfg.rounding      <= '0;
      cfg.shift_amount  <= '0;
      cfg.zero_point    <= '0;
      cfg.clamp_min     <= '0;
      cfg.clamp_max     <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qap_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[qap_pkg::COUNT_W-1:0];
        qap_pkg::REG_BIAS:          cfg.bias          <= cfg_data[qap_pkg::ACC_W-1:0];
        qap_pkg::REG_MULTIPLIER:    cfg.multiplier    <= cfg_data[qap_pkg::ACC_W-1:0];
        qap_pkg::REG_ROUNDING:      cfg.rounding      <= cfg_data[qap_pkg::ROUND_W-1:0];
        qap_pkg::REG_SHIFT_AMOUNT:  cfg.shift_amount  <= cfg_data[qap_pkg::SHIFT_W-1:0];
        qap_pkg::REG_ZERO_POINT:    cfg.zero_point    <= cfg_data[qap_pkg::ZP_W-1:0];
        qap_pkg::REG_CLAMP_MIN:     cfg.clamp_min     <= cfg_data[qap_pkg::VALUE_W-1:0];
        qap_pkg::REG_CLAMP_MAX:     cfg.clamp_max     <= cfg_data[qap_pkg::VALUE_W-1:0];
      endcase
    end
  end

  qap_front u_front (
    .clk           (clk),
    .rst           (rst),
    .items         (items),
    .channel_count (cfg.channel_count),
    .bias          (cfg.bias),
    .push_valid    (push_valid),
    .push_item     (push_item),
    .push_ready    (push_ready)
  );

  qap_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  qap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .results   (results)
  );

endmodule

// ===== design/qap_checker.sv =====
// Port-level checks for the quantized average pool unit, bound to the top.
// Depends on qap_pkg and quantized_average_pool_unit.
`timescale 1ns / 1ps

module qap_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [qap_pkg::VALUE_W-1:0] out_value,
  input logic [qap_pkg::CH_W-1:0]    out_channel
);

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Reset leaves the input side able to take an item
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_channel))
    else $error("result payload changed while stalled");

endmodule

bind quantized_average_pool_unit qap_checker u_qap_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_value   (results.out_value),
  .out_channel (results.out_channel)
);
